// File: hw/rtl/gdn_pkg.sv
// shared types, constants and month tables for the date pair block
`timescale 1ns / 1ps

package gdn_pkg;

    // field widths
    localparam int YEAR_BITS = 14;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int DN_W      = 23;
    localparam int WD_W      = 3;
    localparam int GAP_W     = 24;

    // full day number width: below 366 * 2^YEAR_BITS
    localparam int NUM_W  = YEAR_BITS + 9;
    localparam int DIFF_W = (NUM_W > GAP_W) ? NUM_W : GAP_W;
    localparam int MT_W   = 9;

    // pipeline depth: three date stages, two result stages
    localparam int NUM_STAGES  = 5;
    localparam int DATE_STAGES = 3;

    // year/100 taken as (year/4)/25 by reciprocal, exact for quotients below 2^30
    localparam int          PROD_W        = 48;
    localparam logic [27:0] RECIP25       = 28'd171798692;
    localparam int          RECIP25_SHIFT = 32;

    localparam int DAYS_PER_YEAR = 365;

    // base-8 digit sum of a day number, folded later modulo 7
    localparam int OCT_DIGITS = (NUM_W + 2) / 3;
    localparam int OCT_W      = 3 * OCT_DIGITS;
    localparam int SUM_W      = 8;

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [WD_W-1:0] WEEKDAY_SUNDAY = 3'd7;

    typedef struct packed {
        logic [DAY_W-1:0]     first_day;
        logic [MONTH_W-1:0]   first_month;
        logic [YEAR_BITS-1:0] first_year;
        logic [DAY_W-1:0]     second_day;
        logic [MONTH_W-1:0]   second_month;
        logic [YEAR_BITS-1:0] second_year;
    } gdn_in_t;

    typedef struct packed {
        logic [DN_W-1:0]         first_day_number;
        logic [WD_W-1:0]         first_weekday;
        logic                    first_valid;
        logic                    second_valid;
        logic signed [GAP_W-1:0] day_gap;
    } gdn_out_t;

    // days in the months before the given month, common year
    function automatic logic [MT_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [MT_W-1:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // length of the given month, common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd2:                     r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

    // modulo 7 of an 8-bit digit sum, using 8 = 1 and 64 = 1 mod 7
    function automatic logic [2:0] mod7_fold(input logic [SUM_W-1:0] s);
        logic [4:0] t;
        logic [3:0] u;
        logic [3:0] w;
        t = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[7:6]);
        u = 4'(t[2:0]) + 4'(t[4:3]);
        w = (u >= 4'd7) ? (u - 4'd7) : u;
        return w[2:0];
    endfunction

endpackage

// File: hw/rtl/gdn_date_calc.sv
// three-stage check and day number of one date
`timescale 1ns / 1ps

module gdn_date_calc
    import gdn_pkg::*;
(
    input  logic                   aclk,
    input  logic [DATE_STAGES-1:0] ld,
    input  logic [DAY_W-1:0]       day,
    input  logic [MONTH_W-1:0]     month,
    input  logic [YEAR_BITS-1:0]   year,
    output logic [NUM_W-1:0]       num,
    output logic                   num_valid
);

    // stage 1: range checks and year/100
    logic [YEAR_BITS-3:0] quarter;
    logic [PROD_W-1:0]    prod;
    logic [YEAR_BITS-1:0] q100_next;
    logic                 ok1_next;

    logic [DAY_W-1:0]     d1_reg;
    logic [MONTH_W-1:0]   m1_reg;
    logic [YEAR_BITS-1:0] y1_reg;
    logic [YEAR_BITS-1:0] q100_reg;
    logic                 ok1_reg;

    assign quarter   = year[YEAR_BITS-1:2];
    assign prod      = PROD_W'(quarter) * PROD_W'(RECIP25);
    assign q100_next = YEAR_BITS'(prod >> RECIP25_SHIFT);
    assign ok1_next  = (year != '0) && (month != '0) && (month <= MONTH_DEC) && (day != '0);

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            d1_reg   <= day;
            m1_reg   <= month;
            y1_reg   <= year;
            q100_reg <= q100_next;
            ok1_reg  <= ok1_next;
        end
    end

    // stage 2: leap year, month limit and the three partial terms
    logic [YEAR_BITS-1:0] rem100;
    logic                 leap;
    logic [DAY_W-1:0]     lim;
    logic                 valid2_next;
    logic [NUM_W-1:0]     base_next;
    logic [YEAR_BITS-1:0] lcnt_next;
    logic [MT_W-1:0]      mterm_next;

    logic                 valid2_reg;
    logic [NUM_W-1:0]     base_reg;
    logic [YEAR_BITS-1:0] lcnt_reg;
    logic [MT_W-1:0]      mterm_reg;

    always_comb begin
        rem100 = y1_reg - YEAR_BITS'(32'(q100_reg) * 32'd100);
        leap   = (y1_reg[1:0] == 2'b00) && ((rem100 != '0) || (q100_reg[1:0] == 2'b00));
        lim    = month_len(m1_reg);
        if ((m1_reg == MONTH_FEB) && leap) begin
            lim = 5'd29;
        end
        valid2_next = ok1_reg && (d1_reg <= lim);
        base_next   = NUM_W'(NUM_W'(y1_reg - YEAR_BITS'(1)) * NUM_W'(DAYS_PER_YEAR));
        lcnt_next   = YEAR_BITS'(y1_reg >> 2) - q100_reg + YEAR_BITS'(q100_reg >> 2);
        mterm_next  = days_before(m1_reg) + MT_W'(d1_reg)
                    - MT_W'((m1_reg <= MONTH_FEB) && leap);
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            valid2_reg <= valid2_next;
            base_reg   <= base_next;
            lcnt_reg   <= lcnt_next;
            mterm_reg  <= mterm_next;
        end
    end

    // stage 3: final sum, zero for a date that does not exist
    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] num_reg;
    logic             valid3_reg;

    assign num_next = valid2_reg ? (base_reg + NUM_W'(lcnt_reg) + NUM_W'(mterm_reg)) : '0;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            num_reg    <= num_next;
            valid3_reg <= valid2_reg;
        end
    end

    assign num       = num_reg;
    assign num_valid = valid3_reg;

endmodule

// File: hw/rtl/gdn_result.sv
// two-stage weekday, gap and output register
`timescale 1ns / 1ps

module gdn_result
    import gdn_pkg::*;
(
    input  logic             aclk,
    input  logic [1:0]       ld,
    input  logic [NUM_W-1:0] num1,
    input  logic             valid1,
    input  logic [NUM_W-1:0] num2,
    input  logic             valid2,
    output gdn_out_t         result
);

    // stage 4: octal digit sum of the first number, gap and truncation
    logic [OCT_W-1:0]  padded;
    logic [SUM_W-1:0]  sum_next;
    logic [DIFF_W-1:0] diff;

    logic [SUM_W-1:0]  sum_reg;
    logic [DN_W-1:0]   dn_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic              v1_reg;
    logic              v2_reg;

    always_comb begin
        padded   = OCT_W'(num1);
        sum_next = '0;
        for (int i = 0; i < OCT_DIGITS; i++) begin
            sum_next = sum_next + SUM_W'(padded[3*i +: 3]);
        end
        diff = DIFF_W'(num2) - DIFF_W'(num1);
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            sum_reg <= sum_next;
            dn_reg  <= DN_W'(num1);
            gap_reg <= (valid1 && valid2) ? diff[GAP_W-1:0] : '0;
            v1_reg  <= valid1;
            v2_reg  <= valid2;
        end
    end

    // stage 5: weekday from the digit sum, with 0 shown as 7
    logic [2:0]      rem7;
    logic [WD_W-1:0] wd;
    gdn_out_t        result_reg;

    always_comb begin
        rem7 = mod7_fold(sum_reg);
        if (!v1_reg) begin
            wd = '0;
        end else if (rem7 == 3'd0) begin
            wd = WEEKDAY_SUNDAY;
        end else begin
            wd = rem7;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            result_reg.first_day_number <= dn_reg;
            result_reg.first_weekday    <= wd;
            result_reg.first_valid      <= v1_reg;
            result_reg.second_valid     <= v2_reg;
            result_reg.day_gap          <= $signed(gap_reg);
        end
    end

    assign result = result_reg;

endmodule

// File: hw/rtl/gregorian_day_number_weekday_gap.sv
// top level: date pair to day number, weekday and gap
`timescale 1ns / 1ps
//
// Each request on the s_ channel carries two Gregorian dates (day, month,
// year). Each result on the m_ channel gives the first date's day number
// (0001-01-01 is day 1), its weekday 1 to 7 with Monday as 1, the second
// minus first gap, and one flag per date telling whether it exists.
// Fields of a date that does not exist read 0, and the gap is 0 unless
// both dates exist.
//
// Both channels use valid/ready. The block is a five-stage pipeline:
// three stages per date (range checks and year/100, leap test and partial
// terms, final sum) and two shared stages (digit sum and gap, weekday and
// output register). One request is taken every cycle unless a stalled
// receiver has filled the pipeline back to the first stage.
//
// Each stage holds its contents while the one after it is full and
// stalled, so a stalled receiver fills the pipeline from the output back;
// s_ready falls only when all five stages are full. Synchronous reset
// empties every stage; no memory needs clearing.
//
module gregorian_day_number_weekday_gap
    import gdn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gdn_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output gdn_out_t m_data
);

    // stage occupancy and per-stage load enables
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] rdy;

    always_comb begin
        rdy[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        v_next[0] = rdy[0] ? s_valid : v_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NUM_STAGES-1];

    // per-date day numbers
    logic [NUM_W-1:0] num1;
    logic [NUM_W-1:0] num2;
    logic             valid1;
    logic             valid2;

    gdn_date_calc u_first (
        .aclk      (aclk),
        .ld        (rdy[DATE_STAGES-1:0]),
        .day       (s_data.first_day),
        .month     (s_data.first_month),
        .year      (s_data.first_year),
        .num       (num1),
        .num_valid (valid1)
    );

    gdn_date_calc u_second (
        .aclk      (aclk),
        .ld        (rdy[DATE_STAGES-1:0]),
        .day       (s_data.second_day),
        .month     (s_data.second_month),
        .year      (s_data.second_year),
        .num       (num2),
        .num_valid (valid2)
    );

    // weekday, gap and output register
    gdn_result u_result (
        .aclk   (aclk),
        .ld     (rdy[NUM_STAGES-1:DATE_STAGES]),
        .num1   (num1),
        .valid1 (valid1),
        .num2   (num2),
        .valid2 (valid2),
        .result (m_data)
    );

    // an empty output stage lets the whole chain take a request
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with an empty output stage");

    // a date that does not exist carries no number and no weekday
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.first_valid) |->
            (m_data.first_day_number == '0) && (m_data.first_weekday == '0))
        else $error("nonzero number or weekday for a missing first date");

    // a real date always has a weekday from 1 to 7
    a_weekday_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.first_valid) |-> (m_data.first_weekday != '0))
        else $error("weekday 0 for an existing first date");

    // the gap is zero unless both dates exist
    a_gap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !(m_data.first_valid && m_data.second_valid)) |->
            (m_data.day_gap == '0))
        else $error("nonzero gap with a missing date");

    // an accepted request always lands in the first stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) |-> ##1 v_reg[0])
        else $error("accepted request not held in the first stage");

endmodule
